FILE: hdl/button_edge_autorepeat_scanner_assert.svh
// Assertion macros used by the scanner's top-level RTL file.
`ifndef BUTTON_EDGE_AUTOREPEAT_SCANNER_ASSERT_SVH
`define BUTTON_EDGE_AUTOREPEAT_SCANNER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BEAS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BEAS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/beas_pkg.sv
// Types, codes and lookup functions for the button edge / auto-repeat scanner.
package beas_pkg;

  // Fixed field widths
  localparam int unsigned BtnWidth  = 16;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 8;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgStickMask   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgBtnPeriod   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgStickPeriod = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgStickLow    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgStickHigh   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgHoldThr     = 3'd5;

  // Configuration reset values
  localparam logic [3:0] RstStickMask   = 4'h3;
  localparam logic [7:0] RstBtnPeriod   = 8'd3;
  localparam logic [7:0] RstStickPeriod = 8'd1;
  localparam logic [7:0] RstStickLow    = 8'd38;
  localparam logic [7:0] RstStickHigh   = 8'd218;
  localparam logic [7:0] RstHoldThr     = 8'd10;
  localparam logic [7:0] HoldMax        = 8'hFF;

  // Event kinds
  localparam logic [1:0] KindNone    = 2'd0;
  localparam logic [1:0] KindPress   = 2'd1;
  localparam logic [1:0] KindRelease = 2'd2;
  localparam logic [1:0] KindRepeat  = 2'd3;

  // Navigation directions
  localparam logic [2:0] NavNone  = 3'd0;
  localparam logic [2:0] NavUp    = 3'd1;
  localparam logic [2:0] NavDown  = 3'd2;
  localparam logic [2:0] NavLeft  = 3'd3;
  localparam logic [2:0] NavRight = 3'd4;

  // D-pad positions
  localparam logic [3:0] PosUp    = 4'd4;
  localparam logic [3:0] PosRight = 4'd5;
  localparam logic [3:0] PosDown  = 4'd6;
  localparam logic [3:0] PosLeft  = 4'd7;

  // Stick direction bits in walk order
  localparam logic [1:0] DirUp    = 2'd0;
  localparam logic [1:0] DirDown  = 2'd1;
  localparam logic [1:0] DirLeft  = 2'd2;
  localparam logic [1:0] DirRight = 2'd3;

  typedef struct packed {
    logic [BtnWidth-1:0] buttons;
    logic [7:0]          stick_x;
    logic [7:0]          stick_y;
  } beas_in_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [3:0] position;
    logic [2:0] nav_dir;
    logic       last;
  } beas_out_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // take the scan request
    logic adv;    // evaluate the current position and move on
    logic flush;  // emit the closing result of the scan
  } beas_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic ev;         // current position produces a result
    logic pend_v;     // a result is waiting in the pending slot
    logic out_free;   // output register can be written this cycle
    logic step_last;  // current position is the last of the walk
  } beas_sts_t;

  // D-pad position of a stick direction
  function automatic logic [3:0] stick_pos(input logic [1:0] dir);
    logic [3:0] p;
    unique case (dir)
      DirUp:    p = PosUp;
      DirDown:  p = PosDown;
      DirLeft:  p = PosLeft;
      DirRight: p = PosRight;
      default:  p = PosUp;
    endcase
    return p;
  endfunction

  // Navigation direction tied to a d-pad position
  function automatic logic [2:0] nav_of(input logic [3:0] pos);
    logic [2:0] n;
    unique case (pos)
      PosUp:    n = NavUp;
      PosDown:  n = NavDown;
      PosLeft:  n = NavLeft;
      PosRight: n = NavRight;
      default:  n = NavNone;
    endcase
    return n;
  endfunction

endpackage

FILE: hdl/beas_ctrl.sv
// Scan controller: accepts a scan, steps the walk, closes the scan.
module beas_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  beas_pkg::beas_sts_t sts_i,
  output beas_pkg::beas_cmd_t cmd_o
);
  import beas_pkg::*;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StWalk  = 2'd1;
  localparam logic [1:0] StFlush = 2'd2;

  logic [1:0] state_q, state_d;
  logic       blocked;

  // A new result cannot move the pending one out while the output is full
  assign blocked = sts_i.ev && sts_i.pend_v && !sts_i.out_free;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StWalk;
        end
      end
      StWalk: begin
        if (!blocked) begin
          cmd_o.adv = 1'b1;
          if (sts_i.step_last) begin
            state_d = StFlush;
          end
        end
      end
      StFlush: begin
        if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);

endmodule

FILE: hdl/beas_dp.sv
// Scanner datapath: config registers, scan shift registers, hold/repeat state, outputs.
module beas_dp #(
  parameter int unsigned BUTTON_COUNT = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [beas_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [beas_pkg::CfgDataW-1:0] cfg_data_i,
  input  beas_pkg::beas_in_t           in_data_i,
  input  beas_pkg::beas_cmd_t          cmd_i,
  output beas_pkg::beas_sts_t          sts_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output beas_pkg::beas_out_t          out_data_o
);
  import beas_pkg::*;

  // Positions at or above the mask width never change, so the walk stops there
  localparam int unsigned ScanLen   = (BUTTON_COUNT < BtnWidth) ? BUTTON_COUNT : BtnWidth;
  localparam int unsigned StepCount = ScanLen + 4;
  localparam int unsigned StepW     = $clog2(StepCount);

  // Configuration
  logic [3:0] mask_q;
  logic [7:0] btn_per_q, stk_per_q, low_q, high_q, thr_q;

  // Scan registers
  logic [ScanLen-1:0] cur_sh_q;   // current mask, shifted down one per button step
  logic [ScanLen-1:0] prev_q;     // previous mask, rotated while the new one fills in
  logic [3:0]         dirs_q, pdirs_q;
  logic [StepW-1:0]   step_q;

  // Hold / repeat state
  logic [7:0] hold_q, hold_n, rep_q, rep_n;
  logic       boost_q, boost_n;

  // Pending result and output register
  logic      pend_v_q;
  beas_out_t pend_q;
  logic      out_valid_q;
  beas_out_t out_q;

  // Per-step decode
  logic       in_btn, cur, prv, en, stick, ev;
  logic [1:0] sidx;
  logic [3:0] pos;
  logic [2:0] nav;
  logic [7:0] rc_inc, period, hc;
  logic [1:0] kind;
  logic [2:0] ev_nav;
  logic [3:0] dirs_in;
  logic       out_free, push_mid;
  beas_out_t  fin_res;

  // Threshold the stick axes; left and up win on overlap
  always_comb begin
    dirs_in = '0;
    if (in_data_i.stick_x <= low_q) begin
      dirs_in[DirLeft] = 1'b1;
    end else if (in_data_i.stick_x >= high_q) begin
      dirs_in[DirRight] = 1'b1;
    end
    if (in_data_i.stick_y <= low_q) begin
      dirs_in[DirUp] = 1'b1;
    end else if (in_data_i.stick_y >= high_q) begin
      dirs_in[DirDown] = 1'b1;
    end
  end

  // Edge classification and hold / repeat update for the current position
  always_comb begin
    in_btn = (step_q < StepW'(ScanLen));
    sidx   = 2'(step_q - StepW'(ScanLen));
    if (in_btn) begin
      cur   = cur_sh_q[0];
      prv   = prev_q[0];
      pos   = 4'(step_q);
      en    = 1'b1;
      stick = 1'b0;
    end else begin
      cur   = dirs_q[sidx];
      prv   = pdirs_q[sidx];
      pos   = stick_pos(sidx);
      en    = mask_q[sidx];
      stick = 1'b1;
    end
    nav     = nav_of(pos);
    rc_inc  = rep_q + 8'd1;
    period  = stick ? stk_per_q : btn_per_q;
    hc      = (hold_q != HoldMax) ? (hold_q + 8'd1) : hold_q;
    hold_n  = hold_q;
    boost_n = boost_q;
    rep_n   = rep_q;
    ev      = 1'b0;
    kind    = KindNone;
    ev_nav  = NavNone;
    if (en) begin
      priority if (cur && !prv) begin
        ev     = 1'b1;
        kind   = KindPress;
        ev_nav = nav;
      end else if (!cur && prv) begin
        ev      = 1'b1;
        kind    = KindRelease;
        hold_n  = '0;
        boost_n = 1'b0;
      end else if (cur && prv) begin
        if (boost_q) begin
          if (rc_inc >= period) begin
            rep_n = '0;
            if (nav != NavNone) begin
              ev     = 1'b1;
              kind   = KindRepeat;
              ev_nav = nav;
            end
          end else begin
            rep_n = rc_inc;
          end
        end else begin
          hold_n = hc;
          if (hc > thr_q) begin
            boost_n = 1'b1;
          end
        end
      end else begin
        ev = 1'b0;
      end
    end
  end

  // Output handshake and the closing result
  assign out_free = !out_valid_q || !out_stall_i;
  assign push_mid = cmd_i.adv && ev && pend_v_q;

  always_comb begin
    fin_res = pend_v_q ? pend_q : beas_out_t'('0);
    fin_res.last = 1'b1;
  end

  // Configuration writes; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q    <= RstStickMask;
      btn_per_q <= RstBtnPeriod;
      stk_per_q <= RstStickPeriod;
      low_q     <= RstStickLow;
      high_q    <= RstStickHigh;
      thr_q     <= RstHoldThr;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgStickMask:   mask_q    <= cfg_data_i[3:0];
        CfgBtnPeriod:   btn_per_q <= cfg_data_i;
        CfgStickPeriod: stk_per_q <= cfg_data_i;
        CfgStickLow:    low_q     <= cfg_data_i;
        CfgStickHigh:   high_q    <= cfg_data_i;
        CfgHoldThr:     thr_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Scan state, walk counter and pending slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= '0;
      pdirs_q  <= '0;
      hold_q   <= '0;
      boost_q  <= 1'b0;
      rep_q    <= '0;
      step_q   <= '0;
      pend_v_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        step_q   <= '0;
        pend_v_q <= 1'b0;
      end else if (cmd_i.adv) begin
        step_q  <= step_q + StepW'(1);
        hold_q  <= hold_n;
        boost_q <= boost_n;
        rep_q   <= rep_n;
        if (in_btn) begin
          prev_q <= (prev_q >> 1) | (ScanLen'(cur_sh_q[0]) << (ScanLen - 1));
        end
        if (step_q == StepW'(StepCount - 1)) begin
          pdirs_q <= dirs_q;
        end
        if (ev) begin
          pend_v_q <= 1'b1;
        end
      end else if (cmd_i.flush) begin
        pend_v_q <= 1'b0;
      end
    end
  end

  // Scan payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_sh_q <= in_data_i.buttons[ScanLen-1:0];
      dirs_q   <= dirs_in;
    end else if (cmd_i.adv) begin
      if (in_btn) begin
        cur_sh_q <= cur_sh_q >> 1;
      end
      if (ev) begin
        pend_q.event_kind <= kind;
        pend_q.position   <= pos;
        pend_q.nav_dir    <= ev_nav;
        pend_q.last       <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push_mid || cmd_i.flush) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_mid) begin
      out_q <= pend_q;
    end else if (cmd_i.flush) begin
      out_q <= fin_res;
    end
  end

  assign sts_o.ev        = ev;
  assign sts_o.pend_v    = pend_v_q;
  assign sts_o.out_free  = out_free;
  assign sts_o.step_last = (step_q == StepW'(StepCount - 1));

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: hdl/button_edge_autorepeat_scanner.sv
// Top level of the button edge detector with auto-repeat navigation.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------
//   in      | input     | in_valid_i / in_stall_o | beas_in_t  (buttons, stick)
//   out     | output    | out_valid_o / out_stall_i | beas_out_t (event, pos, nav)
//   cfg     | input     | cfg_valid_i / cfg_ready_o | index 3b, data 8b
//
// A scan request walks min(BUTTON_COUNT,16) buttons plus 4 stick directions, one
// position per cycle while the walk is not paused, then closes with a final result.
// All positions share the single hold/repeat state.
// The walk pauses while the output register is stalled and a second result is ready.
// Reset loads the config defaults and clears all history; no clearing pass.
module button_edge_autorepeat_scanner #(
  parameter int unsigned BUTTON_COUNT = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  beas_pkg::beas_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output beas_pkg::beas_out_t           out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [beas_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [beas_pkg::CfgDataW-1:0] cfg_data_i
);
  import beas_pkg::*;

`include "button_edge_autorepeat_scanner_assert.svh"

  beas_cmd_t cmd;
  beas_sts_t sts;

  // Register writes are always taken
  assign cfg_ready_o = 1'b1;

  beas_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  beas_dp #(
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // A taken scan keeps the input stalled while it is walked
  `BEAS_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "scan accepted but input not stalled")

  // A result is never pushed over an unconsumed output
  `BEAS_ASSERT_NOW(a_mid_push_free, clk_i, rst_ni, cmd.adv && sts.ev && sts.pend_v, sts.out_free, "pending result pushed over a full output")

  `BEAS_ASSERT_NOW(a_flush_free, clk_i, rst_ni, cmd.flush, sts.out_free, "closing result pushed over a full output")

  // Nothing is left pending once the block is ready for the next scan
  `BEAS_ASSERT_NOW(a_idle_empty, clk_i, rst_ni, !in_stall_o, !sts.pend_v, "pending result left behind at scan end")

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the button edge / auto-repeat scanner.
`timescale 1ns / 1ps

module tb_top;
  import beas_pkg::*;

  localparam int ButtonCount = 16;
  localparam int MaxEvents   = 20;
  localparam int PhaseCount  = 6;
  localparam int PhaseItems  = 75;
  localparam int LongHold    = 300;
  localparam int TailCycles  = 50;
  localparam int DrainLimit  = 20000;

  // Indexes with no register behind them
  localparam logic [CfgIdxW-1:0] CfgUnusedLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgUnusedHi = 3'd7;

  typedef struct packed {
    logic [3:0] stick_mask;
    logic [7:0] btn_period;
    logic [7:0] stick_period;
    logic [7:0] low_thr;
    logic [7:0] high_thr;
    logic [7:0] hold_thr;
  } scan_cfg_t;

  typedef struct packed {
    beas_in_t  scan;
    logic      typed;
    beas_out_t want;
  } probe_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  beas_in_t            in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  beas_out_t           out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // Predictor state: register mirror and scan history
  scan_cfg_t      live_cfg = '{RstStickMask, RstBtnPeriod, RstStickPeriod,
                               RstStickLow, RstStickHigh, RstHoldThr};
  logic [15:0]    last_buttons = '0;
  logic [3:0]     last_dirs = '0;
  logic [7:0]     hold_cnt = '0;
  logic           boost = 1'b0;
  logic [7:0]     rpt_cnt = '0;

  beas_out_t      scan_events[$];
  beas_out_t      pending_events[$];
  int             mismatch_count = 0;
  int             idle_pct = 0;
  bit             quiet_tail = 1'b0;
  bit             rx_hold_req = 1'b0;

  // Directed scans, run at reset settings; typed rows carry their single result
  probe_t probes [20] = '{
    '{'{16'h0000, 8'd128, 8'd128}, 1'b1, '{KindNone, 4'd0, NavNone, 1'b1}},
    '{'{16'h0001, 8'd128, 8'd128}, 1'b1, '{KindPress, 4'd0, NavNone, 1'b1}},
    '{'{16'h0000, 8'd128, 8'd128}, 1'b1, '{KindRelease, 4'd0, NavNone, 1'b1}},
    '{'{16'h0010, 8'd128, 8'd128}, 1'b1, '{KindPress, PosUp, NavUp, 1'b1}},
    '{'{16'h0010, 8'd128, 8'd128}, 1'b1, '{KindNone, 4'd0, NavNone, 1'b1}},
    '{'{16'h0000, 8'd128, 8'd128}, 1'b1, '{KindRelease, PosUp, NavNone, 1'b1}},
    '{'{16'h0080, 8'd0, 8'd128}, 1'b1, '{KindPress, PosLeft, NavLeft, 1'b1}},
    '{'{16'h0000, 8'd255, 8'd128}, 1'b1, '{KindRelease, PosLeft, NavNone, 1'b1}},
    '{'{16'hFFFF, 8'd128, 8'd0}, 1'b0, '0},
    '{'{16'hFFFF, 8'd128, 8'd0}, 1'b0, '0},
    '{'{16'hFFFF, 8'd128, 8'd0}, 1'b0, '0},
    '{'{16'hFFFF, 8'd128, 8'd255}, 1'b0, '0},
    '{'{16'h0000, 8'd128, 8'd128}, 1'b0, '0},
    '{'{16'h5555, 8'd0, 8'd38}, 1'b0, '0},
    '{'{16'hAAAA, 8'd218, 8'd218}, 1'b0, '0},
    '{'{16'hFFFF, 8'd37, 8'd219}, 1'b0, '0},
    '{'{16'h0000, 8'd39, 8'd217}, 1'b0, '0},
    '{'{16'h8000, 8'd128, 8'd128}, 1'b1, '{KindPress, 4'd15, NavNone, 1'b1}},
    '{'{16'h8000, 8'd128, 8'd128}, 1'b1, '{KindNone, 4'd0, NavNone, 1'b1}},
    '{'{16'h0000, 8'd128, 8'd128}, 1'b1, '{KindRelease, 4'd15, NavNone, 1'b1}}
  };

  button_edge_autorepeat_scanner DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  function automatic logic [2:0] nav_toward(input logic [3:0] pos);
    case (pos)
      PosUp:    return NavUp;
      PosDown:  return NavDown;
      PosLeft:  return NavLeft;
      PosRight: return NavRight;
      default:  return NavNone;
    endcase
  endfunction

  function automatic logic [3:0] dpad_of(input logic [1:0] dir);
    case (dir)
      DirUp:   return PosUp;
      DirDown: return PosDown;
      DirLeft: return PosLeft;
      default: return PosRight;
    endcase
  endfunction

  function automatic void note_event(input logic [1:0] kind, input logic [3:0] pos,
                                     input logic [2:0] nav);
    beas_out_t r;
    if (scan_events.size() >= MaxEvents) return;
    r.event_kind = kind;
    r.position   = pos;
    r.nav_dir    = nav;
    r.last       = 1'b0;
    scan_events.push_back(r);
  endfunction

  // Shared repeat counter; wraps at 8 bits, fires when it reaches the period
  function automatic bit repeat_fires(input bit is_stick);
    logic [7:0] period;
    period  = is_stick ? live_cfg.stick_period : live_cfg.btn_period;
    rpt_cnt = rpt_cnt + 8'd1;
    if (rpt_cnt >= period) begin
      rpt_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void step_position(input bit cur, input bit prv, input logic [3:0] pos,
                                        input bit is_stick);
    if (cur && !prv) begin
      note_event(KindPress, pos, nav_toward(pos));
    end else if (!cur && prv) begin
      hold_cnt = '0;
      boost    = 1'b0;
      note_event(KindRelease, pos, NavNone);
    end else if (cur && prv) begin
      if (boost) begin
        if (repeat_fires(is_stick) && nav_toward(pos) != NavNone)
          note_event(KindRepeat, pos, nav_toward(pos));
      end else begin
        if (hold_cnt != HoldMax) hold_cnt = hold_cnt + 8'd1;
        if (hold_cnt > live_cfg.hold_thr) boost = 1'b1;
      end
    end
  endfunction

  // Fills scan_events with what one scan request produces
  function automatic void predict_scan(input beas_in_t scan);
    logic [3:0] dirs;
    beas_out_t  tail;
    scan_events.delete();
    for (int i = 0; i < ButtonCount; i++)
      step_position(scan.buttons[i], last_buttons[i], 4'(i), 1'b0);
    last_buttons = scan.buttons;

    // Left and up win when both thresholds match
    dirs = '0;
    if (scan.stick_x <= live_cfg.low_thr) dirs[DirLeft] = 1'b1;
    else if (scan.stick_x >= live_cfg.high_thr) dirs[DirRight] = 1'b1;
    if (scan.stick_y <= live_cfg.low_thr) dirs[DirUp] = 1'b1;
    else if (scan.stick_y >= live_cfg.high_thr) dirs[DirDown] = 1'b1;

    // Disabled directions are skipped but still recorded
    for (int d = 0; d < 4; d++)
      if (live_cfg.stick_mask[d])
        step_position(dirs[d], last_dirs[d], dpad_of(2'(d)), 1'b1);
    last_dirs = dirs;

    if (scan_events.size() == 0) note_event(KindNone, 4'd0, NavNone);
    tail = scan_events.pop_back();
    tail.last = 1'b1;
    scan_events.push_back(tail);
  endfunction

  // Axis values around the live thresholds, plus the ends and the middle
  function automatic logic [7:0] pick_axis();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return live_cfg.low_thr;
      3:       return live_cfg.low_thr + 8'd1;
      4:       return live_cfg.high_thr;
      5:       return live_cfg.high_thr - 8'd1;
      6:       return 8'd128;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // ---------------------------------------------------------------- driving

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgStickMask:   live_cfg.stick_mask   = val[3:0];
      CfgBtnPeriod:   live_cfg.btn_period   = val;
      CfgStickPeriod: live_cfg.stick_period = val;
      CfgStickLow:    live_cfg.low_thr      = val;
      CfgStickHigh:   live_cfg.high_thr     = val;
      CfgHoldThr:     live_cfg.hold_thr     = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Offer one scan request, log its expected results, then maybe idle
  task automatic send_scan(input beas_in_t scan, input bit typed, input beas_out_t want);
    int gap;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= scan;
    do @(posedge clk_i); while (in_stall_o);
    predict_scan(scan);
    if (typed) pending_events.push_back(want);
    else foreach (scan_events[k]) pending_events.push_back(scan_events[k]);
    if (!quiet_tail && !rx_hold_req && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 7);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
  endtask

  task automatic apply_cfg(input scan_cfg_t s);
    write_reg(CfgStickMask, {4'($urandom_range(0, 15)), s.stick_mask});
    write_reg(CfgBtnPeriod, s.btn_period);
    write_reg(CfgStickPeriod, s.stick_period);
    write_reg(CfgStickLow, s.low_thr);
    write_reg(CfgStickHigh, s.high_thr);
    write_reg(CfgHoldThr, s.hold_thr);
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin : result_backpressure
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LongHold) @(negedge clk_i);
        rx_hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 99) < idle_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Result checker: compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : result_check
    beas_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_events.size() == 0) begin
        $error("result with nothing expected: event_kind %0d position %0d",
               out_data_o.event_kind, out_data_o.position);
        mismatch_count++;
      end else begin
        want = pending_events.pop_front();
        if (out_data_o.event_kind !== want.event_kind) begin
          $error("event_kind: expected %0d, got %0d", want.event_kind, out_data_o.event_kind);
          mismatch_count++;
        end
        if (out_data_o.position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, out_data_o.position);
          mismatch_count++;
        end
        if (out_data_o.nav_dir !== want.nav_dir) begin
          $error("nav_dir: expected %0d, got %0d", want.nav_dir, out_data_o.nav_dir);
          mismatch_count++;
        end
        if (out_data_o.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_data_o.last);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    #12_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    scan_cfg_t s;
    beas_in_t  base;
    beas_in_t  scan;
    int        run_left;
    int        drain_wait;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    base        = '0;
    run_left    = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed scans at reset settings
    idle_pct = 15;
    foreach (probes[i]) send_scan(probes[i].scan, probes[i].typed, probes[i].want);

    for (int p = 0; p < PhaseCount; p++) begin
      drain_results();
      case (p)
        0: s = '{4'hF, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0};
        1: s = '{4'hF, 8'd255, 8'd255, 8'd255, 8'd0, 8'd254};
        3: s = '{RstStickMask, RstBtnPeriod, RstStickPeriod,
                 RstStickLow, RstStickHigh, RstHoldThr};
        default: begin
          s.stick_mask   = 4'($urandom_range(0, 15));
          s.btn_period   = 8'($urandom_range(0, 1) ? $urandom_range(0, 5) : $urandom_range(0, 255));
          s.stick_period = 8'($urandom_range(0, 1) ? $urandom_range(0, 5) : $urandom_range(0, 255));
          s.low_thr      = 8'($urandom_range(0, 255));
          s.high_thr     = 8'($urandom_range(0, 255));
          s.hold_thr     = 8'($urandom_range(0, 1) ? $urandom_range(0, 12) : $urandom_range(0, 254));
        end
      endcase
      apply_cfg(s);
      // Writes to unused indexes must change nothing
      if (p == 2 || $urandom_range(0, 1)) begin
        write_reg(CfgUnusedLo, 8'($urandom_range(0, 255)));
        write_reg(CfgUnusedHi, 8'($urandom_range(0, 255)));
      end

      case (p)
        2:       idle_pct = 0;
        4:       idle_pct = 35;
        default: idle_pct = 15;
      endcase
      quiet_tail = (p == PhaseCount - 1);

      for (int n = 0; n < PhaseItems; n++) begin
        // Long receiver hold-off while the sender keeps pushing
        if (p == 3 && n == 20) rx_hold_req = 1'b1;

        // Mostly held patterns that run long enough to reach boost and repeat
        if (run_left == 0) begin
          run_left = $urandom_range(1, 24);
          if ($urandom_range(0, 3) == 0) begin
            base = beas_in_t'($urandom);
          end else begin
            base.buttons = 16'($urandom_range(0, 65535)) &
                           (16'h00F0 | (16'h0001 << $urandom_range(0, 15)));
            base.stick_x = pick_axis();
            base.stick_y = pick_axis();
          end
        end
        run_left--;
        scan = base;
        if ($urandom_range(0, 9) == 0) scan = beas_in_t'($urandom);
        else if ($urandom_range(0, 9) == 0) scan.buttons[$urandom_range(0, 15)] ^= 1'b1;
        send_scan(scan, 1'b0, '0);
      end
    end

    // Wind down: wait for outstanding results, then watch for strays
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    drain_wait = 0;
    while (pending_events.size() != 0 && drain_wait < DrainLimit) begin
      @(posedge clk_i);
      drain_wait++;
    end
    repeat (TailCycles) @(posedge clk_i);
    if (pending_events.size() != 0) begin
      $error("%0d expected results never arrived", pending_events.size());
      mismatch_count++;
    end

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: button_edge_autorepeat_scanner.f
+incdir+hdl
hdl/beas_pkg.sv
hdl/beas_ctrl.sv
hdl/beas_dp.sv
hdl/button_edge_autorepeat_scanner.sv
test/tb_top.sv
